>>> rtl/core/msr_pkg.sv
`timescale 1ns / 1ps

package msr_pkg;

    localparam int LEVEL_W          = 16;
    localparam int TIME_W           = 16;
    localparam int WAIT_W           = 10;
    localparam int IO_CHANNELS      = 6;
    localparam int NUM_CHANNELS_DEF = 6;
    localparam int RAMP_STEPS_DEF   = 100;

    localparam logic [WAIT_W-1:0]  WAIT_MAX           = 10'd1023;
    localparam logic [LEVEL_W-1:0] FIRST_LIMIT_RESET  = 16'd1520;
    localparam logic [TIME_W-1:0]  DEFAULT_TIME_RESET = 16'd1000;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_CMD  = 1'b1
    } t_mode;

    typedef enum logic {
        CFG_FIRST_LIMIT  = 1'b0,
        CFG_DEFAULT_TIME = 1'b1
    } t_cfg_idx;

    // Per-lane update strobes, already qualified by the transaction advance.
    typedef struct packed {
        logic load;
        logic advance;
        logic settle;
    } t_lane_ctrl;

endpackage

>>> rtl/core/msr_lane.sv
`timescale 1ns / 1ps

module msr_lane #(
    parameter int RAMP_STEPS = msr_pkg::RAMP_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msr_pkg::t_lane_ctrl         i_ctrl,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal,
    output logic [msr_pkg::LEVEL_W-1:0] o_level
);

    localparam int LEVEL_W   = msr_pkg::LEVEL_W;
    localparam int STEP_W    = $clog2((2 ** LEVEL_W - 1) / RAMP_STEPS + 1) + 1;
    localparam int DIV_SHIFT = LEVEL_W + $clog2(RAMP_STEPS);
    localparam int RECIP_W   = LEVEL_W + 2;
    localparam int PROD_W    = LEVEL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS);

    logic [LEVEL_W-1:0]       r_level;
    logic [LEVEL_W-1:0]       n_level;
    logic [LEVEL_W-1:0]       r_target;
    logic signed [STEP_W-1:0] r_step;

    logic signed [LEVEL_W:0]  w_diff;
    logic                     w_neg;
    logic [LEVEL_W-1:0]       w_mag;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-1:0]        w_quot;
    logic [STEP_W-1:0]        w_q_ext;
    logic signed [STEP_W-1:0] w_step_new;
    logic signed [LEVEL_W:0]  w_new_ext;
    logic signed [LEVEL_W:0]  w_old_ext;

    // Truncating division by the step count through an exact reciprocal.
    always_comb begin
        w_diff     = $signed({1'b0, i_goal}) - $signed({1'b0, r_level});
        w_neg      = w_diff[LEVEL_W];
        w_mag      = w_neg ? LEVEL_W'(-w_diff) : w_diff[LEVEL_W-1:0];
        w_prod     = PROD_W'(w_mag) * PROD_W'(RECIP);
        w_quot     = w_prod >> DIV_SHIFT;
        w_q_ext    = {1'b0, w_quot[STEP_W-2:0]};
        w_step_new = w_neg ? $signed(~w_q_ext + STEP_W'(1)) : $signed(w_q_ext);
        w_new_ext  = (LEVEL_W + 1)'(w_step_new);
        w_old_ext  = (LEVEL_W + 1)'(r_step);
    end

    always_comb begin
        n_level = r_level;
        priority if (i_ctrl.load) begin
            if (i_ctrl.settle) begin
                n_level = i_goal;
            end else begin
                n_level = r_level + w_new_ext[LEVEL_W-1:0];
            end
        end else if (i_ctrl.advance) begin
            n_level = r_level + w_old_ext[LEVEL_W-1:0];
        end else if (i_ctrl.settle) begin
            n_level = r_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_target <= '0;
            r_step   <= '0;
        end else begin
            r_level <= n_level;
            if (i_ctrl.load) begin
                r_target <= i_goal;
                r_step   <= w_step_new;
            end
        end
    end

    assign o_level = r_level;

endmodule

>>> rtl/core/multi_servo_linear_ramp_unit.sv
`timescale 1ns / 1ps

// Servo position ramp generator for NUM_CHANNELS channels, six on the ports.
// Input channel: i_valid/o_stall carries one transaction per item. A tick
// (mode 0) advances a running ramp; a command (mode 1) loads new goals and a
// move time when idle and goal 0 is nonzero, and is dropped otherwise.
// Output channel: o_valid/i_stall carries exactly one result per item with
// the channel levels, the ramp status and whether the command was taken.
// Configuration: i_cfg_valid/o_cfg_ready writes the goal-0 limit (index 0)
// or the default move time (index 1); it is always ready and must be used
// only while no item is in flight.
// A result is registered when its item leaves the input register, which
// feeds a single pass of reciprocal division and adds into the state and
// result registers. Throughput is one item per cycle unless stalled.
// While the receiver stalls a full result, the item in the input register
// waits and o_stall rises, so at most two items are held.
// Reset (synchronous, active low) clears all levels, steps and goals, stops
// any ramp and restores the register defaults of 1520 and 1000.
module multi_servo_linear_ramp_unit #(
    parameter int NUM_CHANNELS = msr_pkg::NUM_CHANNELS_DEF,
    parameter int RAMP_STEPS   = msr_pkg::RAMP_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal_ch0,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal_ch1,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal_ch2,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal_ch3,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal_ch4,
    input  logic [msr_pkg::LEVEL_W-1:0] i_goal_ch5,
    input  logic [msr_pkg::TIME_W-1:0]  i_move_time,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [msr_pkg::LEVEL_W-1:0] o_level_ch0,
    output logic [msr_pkg::LEVEL_W-1:0] o_level_ch1,
    output logic [msr_pkg::LEVEL_W-1:0] o_level_ch2,
    output logic [msr_pkg::LEVEL_W-1:0] o_level_ch3,
    output logic [msr_pkg::LEVEL_W-1:0] o_level_ch4,
    output logic [msr_pkg::LEVEL_W-1:0] o_level_ch5,
    output logic                        o_ramp_active,
    output logic                        o_command_taken,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [msr_pkg::LEVEL_W-1:0] i_cfg_data
);

    localparam int LEVEL_W   = msr_pkg::LEVEL_W;
    localparam int TIME_W    = msr_pkg::TIME_W;
    localparam int WAIT_W    = msr_pkg::WAIT_W;
    localparam int IO_CH     = msr_pkg::IO_CHANNELS;
    localparam int STEPS_W   = $clog2(RAMP_STEPS + 1);
    localparam int DIV_SHIFT = TIME_W + $clog2(RAMP_STEPS);
    localparam int RECIP_W   = TIME_W + 2;
    localparam int PROD_W    = TIME_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS);
    localparam logic [STEPS_W-1:0] LAST_STEP = STEPS_W'(RAMP_STEPS);

    // Configuration registers.
    logic [LEVEL_W-1:0] r_first_limit;
    logic [TIME_W-1:0]  r_default_time;

    // Input register.
    logic               r_in_valid;
    msr_pkg::t_mode     r_in_mode;
    logic [LEVEL_W-1:0] r_in_goal [IO_CH];
    logic [TIME_W-1:0]  r_in_time;

    // Ramp sequencing state and result flags.
    logic [STEPS_W-1:0] r_steps_done;
    logic [STEPS_W-1:0] n_steps_done;
    logic [WAIT_W-1:0]  r_wait_left;
    logic [WAIT_W-1:0]  n_wait_left;
    logic [WAIT_W-1:0]  r_wait_period;
    logic [WAIT_W-1:0]  n_wait_period;
    logic               r_running;
    logic               n_running;
    logic               r_taken;
    logic               r_out_valid;

    logic               w_proc;
    logic               w_is_cmd;
    logic               w_take;
    logic               w_tick;
    logic [TIME_W-1:0]  w_time;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]  w_quot;
    logic [WAIT_W-1:0]  w_per;
    logic               w_per_zero;
    logic [WAIT_W-1:0]  w_wait_dec;
    logic               w_expire;
    logic               w_more;
    logic [LEVEL_W-1:0] w_goal0;
    logic [LEVEL_W-1:0] w_port_goal [IO_CH];
    logic [LEVEL_W-1:0] w_level [NUM_CHANNELS];
    logic [LEVEL_W-1:0] w_out_level [IO_CH];
    msr_pkg::t_lane_ctrl w_ctrl;

    assign w_port_goal[0] = i_goal_ch0;
    assign w_port_goal[1] = i_goal_ch1;
    assign w_port_goal[2] = i_goal_ch2;
    assign w_port_goal[3] = i_goal_ch3;
    assign w_port_goal[4] = i_goal_ch4;
    assign w_port_goal[5] = i_goal_ch5;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_limit  <= msr_pkg::FIRST_LIMIT_RESET;
            r_default_time <= msr_pkg::DEFAULT_TIME_RESET;
        end else if (i_cfg_valid) begin
            unique case (msr_pkg::t_cfg_idx'(i_cfg_index))
                msr_pkg::CFG_FIRST_LIMIT: begin
                    r_first_limit <= i_cfg_data;
                end
                msr_pkg::CFG_DEFAULT_TIME: begin
                    r_default_time <= i_cfg_data;
                end
                default: begin
                    r_first_limit <= r_first_limit;
                end
            endcase
        end
    end

    assign w_proc  = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_mode <= msr_pkg::t_mode'(i_mode);
            r_in_time <= i_move_time;
            for (int c = 0; c < IO_CH; c++) begin
                r_in_goal[c] <= w_port_goal[c];
            end
        end
    end

    always_comb begin
        w_is_cmd   = (r_in_mode == msr_pkg::MODE_CMD);
        w_take     = w_proc && w_is_cmd && !r_running && (r_in_goal[0] != '0);
        w_tick     = w_proc && !w_is_cmd && r_running;
        w_time     = (r_in_time == '0) ? r_default_time : r_in_time;
        w_prod     = PROD_W'(w_time) * PROD_W'(RECIP);
        w_quot     = w_prod >> DIV_SHIFT;
        w_per      = (w_quot > PROD_W'(msr_pkg::WAIT_MAX)) ? msr_pkg::WAIT_MAX
                                                            : w_quot[WAIT_W-1:0];
        w_per_zero = (w_per == '0);
        w_goal0    = (r_in_goal[0] > r_first_limit) ? r_first_limit : r_in_goal[0];
        w_wait_dec = (r_wait_left != '0) ? r_wait_left - WAIT_W'(1) : r_wait_left;
        w_expire   = (w_wait_dec == '0);
        w_more     = (r_steps_done < LAST_STEP);
    end

    always_comb begin
        w_ctrl.load    = w_take;
        w_ctrl.advance = (w_take && !w_per_zero) || (w_tick && w_expire && w_more);
        w_ctrl.settle  = (w_take && w_per_zero) || (w_tick && w_expire && !w_more);

        n_steps_done  = r_steps_done;
        n_wait_left   = r_wait_left;
        n_wait_period = r_wait_period;
        n_running     = r_running;
        priority if (w_take) begin
            n_wait_period = w_per;
            n_wait_left   = w_per;
            n_steps_done  = w_per_zero ? STEPS_W'(0) : STEPS_W'(1);
            n_running     = !w_per_zero;
        end else if (w_tick) begin
            if (w_expire && w_more) begin
                n_steps_done = r_steps_done + STEPS_W'(1);
                n_wait_left  = r_wait_period;
            end else begin
                n_wait_left = w_wait_dec;
                if (w_expire) begin
                    n_running = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_done  <= '0;
            r_wait_left   <= '0;
            r_wait_period <= '0;
            r_running     <= 1'b0;
            r_taken       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_steps_done  <= n_steps_done;
            r_wait_left   <= n_wait_left;
            r_wait_period <= n_wait_period;
            r_running     <= n_running;
            if (w_proc) begin
                r_taken     <= w_take;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    for (genvar gc = 0; gc < NUM_CHANNELS; gc++) begin : g_lane
        logic [LEVEL_W-1:0] w_goal;
        if (gc == 0) begin : g_first
            assign w_goal = w_goal0;
        end else if (gc < IO_CH) begin : g_port
            assign w_goal = r_in_goal[gc];
        end else begin : g_extra
            assign w_goal = '0;
        end

        msr_lane #(
            .RAMP_STEPS (RAMP_STEPS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_goal  (w_goal),
            .o_level (w_level[gc])
        );
    end

    for (genvar go = 0; go < IO_CH; go++) begin : g_out
        if (go < NUM_CHANNELS) begin : g_used
            assign w_out_level[go] = w_level[go];
        end else begin : g_unused
            assign w_out_level[go] = '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_level_ch0     = w_out_level[0];
    assign o_level_ch1     = w_out_level[1];
    assign o_level_ch2     = w_out_level[2];
    assign o_level_ch3     = w_out_level[3];
    assign o_level_ch4     = w_out_level[4];
    assign o_level_ch5     = w_out_level[5];
    assign o_ramp_active   = r_running;
    assign o_command_taken = r_taken;

`ifndef SYNTHESIS
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while the result register is empty");

    a_idle_no_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_wait_left == '0))
        else $error("wait counter left nonzero while idle");

    a_running_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_wait_left != '0) && (r_wait_left <= r_wait_period))
        else $error("wait counter out of range during a ramp");

    a_running_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_steps_done != '0) && (r_steps_done <= LAST_STEP))
        else $error("step count out of range during a ramp");

    a_taken_from_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_taken && o_valid)
        else $error("taken command not reported in the next result");
`endif

endmodule
